// ===== rtl/cvm_pkg.sv =====
package cvm_pkg;

   // Default component width; the limit is one bit narrower
   localparam int unsigned CVM_DATA_WIDTH = 24;

   // Stages in the front end (magnitude, squares, sum and compare)
   localparam int unsigned CVM_PREP_STAGES = 3;

endpackage

// ===== rtl/clamp_vector_magnitude.sv =====
// Vector magnitude clamp for signed fixed-point 2D vectors.
// Input channel (req_): in_x, in_y and max_length, taken when req_valid and
// req_ready are both high. Result channel (rsp_): out_x and out_y, one result
// per item, in the order the items came in.
// A vector whose squared length does not exceed max_length squared leaves
// unchanged; any other is scaled to max_length, each component truncated
// toward zero.
// From acceptance to the result, an item passes three front-end stages,
// one square-root cell per root bit, one divider cell per quotient bit, then
// the output register.
// Throughput: one item per cycle unless stalled; every cell holds one item.
// Each cell holds its item while the one below is full and stalled, so a
// stalled receiver fills the chain up before req_ready drops, and bubbles close up.
// Reset clears all valid flags; the block keeps no other state.
module clamp_vector_magnitude #(
   parameter int unsigned DATA_WIDTH = cvm_pkg::CVM_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_in_x,
   input  logic signed [DATA_WIDTH-1:0] req_in_y,
   input  logic        [DATA_WIDTH-2:0] req_max_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_out_x,
   output logic signed [DATA_WIDTH-1:0] rsp_out_y
);
   import cvm_pkg::*;

   localparam int unsigned W   = DATA_WIDTH;
   localparam int unsigned SSW = 1 + 2*W + 2*(2*W-1);
   localparam int unsigned DSW = 1 + 2*W;

   logic           p_valid, p_ready, p_clamp;
   logic [2*W-1:0] p_sum;
   logic [W-1:0]   p_x, p_y;
   logic [2*W-2:0] p_px, p_py;

   logic           s_valid [0:W];
   logic           s_ready [0:W];
   logic [2*W-1:0] s_sum   [0:W];
   logic [W+1:0]   s_rem   [0:W];
   logic [W-1:0]   s_root  [0:W];
   logic [SSW-1:0] s_side  [0:W];

   logic           d_valid [0:W-1];
   logic           d_ready [0:W-1];
   logic [W-1:0]   d_len   [0:W-1];
   logic [W-1:0]   d_rx    [0:W-1];
   logic [W-1:0]   d_ry    [0:W-1];
   logic [W-2:0]   d_lx    [0:W-1];
   logic [W-2:0]   d_ly    [0:W-1];
   logic [W-2:0]   d_qx    [0:W-1];
   logic [W-2:0]   d_qy    [0:W-1];
   logic [DSW-1:0] d_side  [0:W-1];

   logic           e_clamp;
   logic [W-1:0]   e_x, e_y;
   logic [2*W-2:0] e_px, e_py;
   logic           f_clamp;
   logic [W-1:0]   f_x, f_y, qx_ext, qy_ext, ox_in, oy_in;

   logic           rsp_valid_ff;
   logic [W-1:0]   rsp_x_ff, rsp_y_ff;
   logic           fin_ready;

   // Front end: magnitudes, products, sum of squares, clamp decision
   cvm_prep #(.W(W)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_lim    (req_max_length),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_sum   (p_sum),
      .out_clamp (p_clamp),
      .out_x     (p_x),
      .out_y     (p_y),
      .out_px    (p_px),
      .out_py    (p_py)
   );

   // Square-root chain: one root bit per cell
   assign s_valid[0] = p_valid;
   assign p_ready    = s_ready[0];
   assign s_sum[0]   = p_sum;
   assign s_rem[0]   = '0;
   assign s_root[0]  = '0;
   assign s_side[0]  = {p_clamp, p_x, p_y, p_px, p_py};

   for (genvar i = 0; i < W; i++) begin : g_sqrt
      cvm_sqrt_cell #(.W(W), .SW(SSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (s_valid[i]),
         .up_ready (s_ready[i]),
         .up_sum   (s_sum[i]),
         .up_rem   (s_rem[i]),
         .up_root  (s_root[i]),
         .up_side  (s_side[i]),
         .dn_valid (s_valid[i+1]),
         .dn_ready (s_ready[i+1]),
         .dn_sum   (s_sum[i+1]),
         .dn_rem   (s_rem[i+1]),
         .dn_root  (s_root[i+1]),
         .dn_side  (s_side[i+1])
      );
   end

   // Divider chain: quotient fits in W-1 bits, so start from the upper half
   assign {e_clamp, e_x, e_y, e_px, e_py} = s_side[W];
   assign d_valid[0]  = s_valid[W];
   assign s_ready[W]  = d_ready[0];
   assign d_len[0]    = s_root[W];
   assign d_rx[0]     = e_px[2*W-2:W-1];
   assign d_ry[0]     = e_py[2*W-2:W-1];
   assign d_lx[0]     = e_px[W-2:0];
   assign d_ly[0]     = e_py[W-2:0];
   assign d_qx[0]     = '0;
   assign d_qy[0]     = '0;
   assign d_side[0]   = {e_clamp, e_x, e_y};

   for (genvar j = 0; j < W-1; j++) begin : g_div
      cvm_div_cell #(.W(W), .SW(DSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (d_valid[j]),
         .up_ready (d_ready[j]),
         .up_len   (d_len[j]),
         .up_rx    (d_rx[j]),
         .up_ry    (d_ry[j]),
         .up_lx    (d_lx[j]),
         .up_ly    (d_ly[j]),
         .up_qx    (d_qx[j]),
         .up_qy    (d_qy[j]),
         .up_side  (d_side[j]),
         .dn_valid (d_valid[j+1]),
         .dn_ready (d_ready[j+1]),
         .dn_len   (d_len[j+1]),
         .dn_rx    (d_rx[j+1]),
         .dn_ry    (d_ry[j+1]),
         .dn_lx    (d_lx[j+1]),
         .dn_ly    (d_ly[j+1]),
         .dn_qx    (d_qx[j+1]),
         .dn_qy    (d_qy[j+1]),
         .dn_side  (d_side[j+1])
      );
   end

   // Restore signs on clamped items, pass the rest through as received
   assign {f_clamp, f_x, f_y} = d_side[W-1];
   assign qx_ext = {1'b0, d_qx[W-1]};
   assign qy_ext = {1'b0, d_qy[W-1]};
   assign ox_in  = !f_clamp ? f_x : (f_x[W-1] ? (W)'(-qx_ext) : qx_ext);
   assign oy_in  = !f_clamp ? f_y : (f_y[W-1] ? (W)'(-qy_ext) : qy_ext);

   assign fin_ready      = !rsp_valid_ff || rsp_ready;
   assign d_ready[W-1]   = fin_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         rsp_valid_ff <= d_valid[W-1];
      end
      if (fin_ready && d_valid[W-1]) begin
         rsp_x_ff <= ox_in;
         rsp_y_ff <= oy_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;

   // An empty output register never blocks the chain
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> d_ready[W-1] && s_ready[W])
      else $error("chain stalled with empty output register");

   // A clamped item always reaches the divider with a nonzero length
   a_len_nonzero : assert property (@(posedge clock) disable iff (reset)
      (d_valid[0] && e_clamp) |-> (d_len[0] != '0))
      else $error("clamped item with zero length");

   // Nothing comes out right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

// ===== rtl/cvm_prep.sv =====
module cvm_prep #(
   parameter int unsigned W = cvm_pkg::CVM_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   in_x,
   input  logic signed [W-1:0]   in_y,
   input  logic        [W-2:0]   in_lim,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic        [2*W-1:0] out_sum,
   output logic                  out_clamp,
   output logic        [W-1:0]   out_x,
   output logic        [W-1:0]   out_y,
   output logic        [2*W-2:0] out_px,
   output logic        [2*W-2:0] out_py
);
   import cvm_pkg::*;

   logic           a_valid_ff, b_valid_ff, c_valid_ff;
   logic           a_ready, b_ready, c_ready;
   logic [W-1:0]   a_ax_ff, a_ay_ff, a_x_ff, a_y_ff;
   logic [W-2:0]   a_lim_ff;
   logic [W-1:0]   ax_in, ay_in;
   logic [2*W-1:0] b_sqx_ff, b_sqy_ff;
   logic [2*W-3:0] b_limsq_ff;
   logic [2*W-2:0] b_px_ff, b_py_ff;
   logic [W-1:0]   b_x_ff, b_y_ff;
   logic [2*W-1:0] c_sum_ff;
   logic [2*W-1:0] sum_in;
   logic           c_clamp_ff;
   logic [2*W-2:0] c_px_ff, c_py_ff;
   logic [W-1:0]   c_x_ff, c_y_ff;

   // Ready ripples back through each stage that holds an item
   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Take magnitudes; the most negative value maps to 2^(W-1)
   assign ax_in = in_x[W-1] ? (W)'(-in_x) : in_x;
   assign ay_in = in_y[W-1] ? (W)'(-in_y) : in_y;

   // Stage A: magnitudes and raw inputs
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_ax_ff  <= ax_in;
         a_ay_ff  <= ay_in;
         a_lim_ff <= in_lim;
         a_x_ff   <= in_x;
         a_y_ff   <= in_y;
      end
   end

   // Stage B: squares and the two scaled components
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_sqx_ff   <= (2*W)'(a_ax_ff) * (2*W)'(a_ax_ff);
         b_sqy_ff   <= (2*W)'(a_ay_ff) * (2*W)'(a_ay_ff);
         b_limsq_ff <= (2*W-2)'(a_lim_ff) * (2*W-2)'(a_lim_ff);
         b_px_ff    <= (2*W-1)'(a_ax_ff) * (2*W-1)'(a_lim_ff);
         b_py_ff    <= (2*W-1)'(a_ay_ff) * (2*W-1)'(a_lim_ff);
         b_x_ff     <= a_x_ff;
         b_y_ff     <= a_y_ff;
      end
   end

   assign sum_in = b_sqx_ff + b_sqy_ff;

   // Stage C: sum of squares and the clamp decision
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_sum_ff   <= sum_in;
         c_clamp_ff <= sum_in > (2*W)'(b_limsq_ff);
         c_px_ff    <= b_px_ff;
         c_py_ff    <= b_py_ff;
         c_x_ff     <= b_x_ff;
         c_y_ff     <= b_y_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_sum   = c_sum_ff;
   assign out_clamp = c_clamp_ff;
   assign out_x     = c_x_ff;
   assign out_y     = c_y_ff;
   assign out_px    = c_px_ff;
   assign out_py    = c_py_ff;

endmodule

// ===== rtl/cvm_sqrt_cell.sv =====
module cvm_sqrt_cell #(
   parameter int unsigned W  = cvm_pkg::CVM_DATA_WIDTH,
   parameter int unsigned SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  logic [2*W-1:0] up_sum,
   input  logic [W+1:0]   up_rem,
   input  logic [W-1:0]   up_root,
   input  logic [SW-1:0]  up_side,
   output logic           dn_valid,
   input  logic           dn_ready,
   output logic [2*W-1:0] dn_sum,
   output logic [W+1:0]   dn_rem,
   output logic [W-1:0]   dn_root,
   output logic [SW-1:0]  dn_side
);
   import cvm_pkg::*;

   logic           valid_ff;
   logic [2*W-1:0] sum_ff;
   logic [W+1:0]   rem_ff;
   logic [W-1:0]   root_ff;
   logic [SW-1:0]  side_ff;
   logic [W+1:0]   part, trial;
   logic           fits;

   assign up_ready = !valid_ff || dn_ready;

   // Bring down the next two bits and try appending a one to the root
   assign part  = {up_rem[W-1:0], up_sum[2*W-1:2*W-2]};
   assign trial = {up_root, 2'b01};
   assign fits  = part >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         sum_ff  <= {up_sum[2*W-3:0], 2'b00};
         rem_ff  <= fits ? part - trial : part;
         root_ff <= {up_root[W-2:0], fits};
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_sum   = sum_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_side  = side_ff;

endmodule

// ===== rtl/cvm_div_cell.sv =====
module cvm_div_cell #(
   parameter int unsigned W  = cvm_pkg::CVM_DATA_WIDTH,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  logic [W-1:0]  up_len,
   input  logic [W-1:0]  up_rx,
   input  logic [W-1:0]  up_ry,
   input  logic [W-2:0]  up_lx,
   input  logic [W-2:0]  up_ly,
   input  logic [W-2:0]  up_qx,
   input  logic [W-2:0]  up_qy,
   input  logic [SW-1:0] up_side,
   output logic          dn_valid,
   input  logic          dn_ready,
   output logic [W-1:0]  dn_len,
   output logic [W-1:0]  dn_rx,
   output logic [W-1:0]  dn_ry,
   output logic [W-2:0]  dn_lx,
   output logic [W-2:0]  dn_ly,
   output logic [W-2:0]  dn_qx,
   output logic [W-2:0]  dn_qy,
   output logic [SW-1:0] dn_side
);
   import cvm_pkg::*;

   logic          valid_ff;
   logic [W-1:0]  len_ff, rx_ff, ry_ff;
   logic [W-2:0]  lx_ff, ly_ff, qx_ff, qy_ff;
   logic [SW-1:0] side_ff;
   logic [W:0]    tx, ty, dvs;
   logic          gex, gey;

   assign up_ready = !valid_ff || dn_ready;

   // Shift in the next dividend bit and subtract the length where it fits
   assign dvs = {1'b0, up_len};
   assign tx  = {up_rx, up_lx[W-2]};
   assign ty  = {up_ry, up_ly[W-2]};
   assign gex = tx >= dvs;
   assign gey = ty >= dvs;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         len_ff  <= up_len;
         rx_ff   <= gex ? (W)'(tx - dvs) : tx[W-1:0];
         ry_ff   <= gey ? (W)'(ty - dvs) : ty[W-1:0];
         lx_ff   <= {up_lx[W-3:0], 1'b0};
         ly_ff   <= {up_ly[W-3:0], 1'b0};
         qx_ff   <= {up_qx[W-3:0], gex};
         qy_ff   <= {up_qy[W-3:0], gey};
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_len   = len_ff;
   assign dn_rx    = rx_ff;
   assign dn_ry    = ry_ff;
   assign dn_lx    = lx_ff;
   assign dn_ly    = ly_ff;
   assign dn_qx    = qx_ff;
   assign dn_qy    = qy_ff;
   assign dn_side  = side_ff;

endmodule

// ===== dv/clamp_vector_magnitude_test.sv =====
module clamp_vector_magnitude_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned W = cvm_pkg::CVM_DATA_WIDTH;
   localparam int unsigned LATENCY = 2 * W + cvm_pkg::CVM_PREP_STAGES;
   localparam int unsigned RANDOM_ITEMS = 1830;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
   } vec_type;

   typedef struct {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic [W-2:0]        lim;
      logic                known;
      vec_type             res;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [W-1:0] req_in_x = '0;
   logic signed [W-1:0] req_in_y = '0;
   logic [W-2:0] req_max_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_out_x;
   logic signed [W-1:0] rsp_out_y;

   vec_type clamped_queue[$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned clamps_sent = 0;
   longint unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic recv_hold = 1'b0;

   clamp_vector_magnitude u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_max_length(req_max_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Floor square root, one result bit at a time
   function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // Scale the vector down to the limit when it is too long
   function automatic vec_type clamp_vector(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                            logic [W-2:0] lim);
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] sq;
      logic [63:0] len;
      logic [63:0] qx;
      logic [63:0] qy;
      vec_type r;
      ax = x[W-1] ? 64'(-64'(x)) : 64'(x);
      ay = y[W-1] ? 64'(-64'(y)) : 64'(y);
      sq = ax * ax + ay * ay;
      if (sq <= 64'(lim) * 64'(lim)) begin
         r.x = x;
         r.y = y;
         return r;
      end
      len = isqrt(sq);
      qx = (ax * 64'(lim)) / len;
      qy = (ay * 64'(lim)) / len;
      r.x = x[W-1] ? W'(-qx) : W'(qx);
      r.y = y[W-1] ? W'(-qy) : W'(qy);
      return r;
   endfunction

   // Offer one item and hold it until accepted; drop valid only while idling
   task automatic send_vector(logic signed [W-1:0] x, logic signed [W-1:0] y,
                              logic [W-2:0] lim, logic known, vec_type res);
      vec_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      want = known ? res : clamp_vector(x, y, lim);
      if (want != {x, y}) clamps_sent++;
      req_valid <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_max_length <= lim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      clamped_queue.push_back(want);
      @(negedge clock);
   endtask

   // Stop offering and wait for every expected result
   task automatic drain();
      req_valid <= 1'b0;
      while (clamped_queue.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [W-1:0] rand_comp();
      case ($urandom_range(3))
         0: return W'($urandom);
         1: return W'($signed($urandom_range(8191)) - 4096);
         2: return $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         default: return W'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   // Receiver stall decision, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      vec_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (clamped_queue.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_out_x, rsp_out_y);
            mismatches++;
         end else begin
            want = clamped_queue.pop_front();
            if (rsp_out_x !== want.x) begin
               $display("%0t: out_x expected %0d got %0d", $time, want.x, rsp_out_x);
               mismatches++;
            end
            if (rsp_out_y !== want.y) begin
               $display("%0t: out_y expected %0d got %0d", $time, want.y, rsp_out_y);
               mismatches++;
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   localparam logic signed [W-1:0] XMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] XMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-2:0] LMAX = '1;

   vector_row_type directed_rows [0:17] = '{
      '{'0, '0, '0, 1'b1, '{'0, '0}},
      '{'0, '0, LMAX, 1'b1, '{'0, '0}},
      '{24'sd4096, '0, '0, 1'b1, '{'0, '0}},
      '{XMIN, XMIN, '0, 1'b1, '{'0, '0}},
      '{XMAX, XMAX, '0, 1'b1, '{'0, '0}},
      '{24'sd3000, -24'sd4000, 23'd5000, 1'b1, '{24'sd3000, -24'sd4000}},
      '{24'sd3000, 24'sd4000, 23'd2500, 1'b1, '{24'sd1500, 24'sd2000}},
      '{-24'sd3000, -24'sd4000, 23'd4999, 1'b0, '{'0, '0}},
      '{XMAX, '0, LMAX, 1'b1, '{XMAX, '0}},
      '{XMIN, '0, LMAX, 1'b0, '{'0, '0}},
      '{'0, XMIN, LMAX, 1'b0, '{'0, '0}},
      '{XMIN, XMIN, LMAX, 1'b0, '{'0, '0}},
      '{XMAX, XMIN, 23'd1, 1'b0, '{'0, '0}},
      '{-24'sd1, 24'sd1, 23'd1, 1'b0, '{'0, '0}},
      '{-24'sd1, '0, 23'd1, 1'b1, '{-24'sd1, '0}},
      '{24'sd1, 24'sd1, '0, 1'b1, '{'0, '0}},
      '{24'sd12345, -24'sd678, 23'd4096, 1'b0, '{'0, '0}},
      '{XMAX, XMAX, LMAX, 1'b0, '{'0, '0}}
   };

   initial begin
      logic [W-2:0] lim;
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, no idling
      foreach (directed_rows[i])
         send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].lim,
                     directed_rows[i].known, directed_rows[i].res);

      // Long receiver hold-off while items keep coming
      recv_hold = 1'b1;
      fork
         begin
            repeat (150) @(negedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 80; i++)
            send_vector(rand_comp(), rand_comp(), (W-1)'($urandom), 1'b0, '{'0, '0});
      join
      drain();

      // Random phases with varying idle and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 50) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 50) : 0;
         for (int i = 0; i < (RANDOM_ITEMS - 80) / 4; i++) begin
            x = rand_comp();
            y = rand_comp();
            case ($urandom_range(3))
               0: lim = (W-1)'($urandom);
               1: lim = $urandom_range(1) ? LMAX : '0;
               2: lim = (W-1)'($urandom_range(10000));
               default: lim = (W-1)'(isqrt(64'(x) * 64'(x) + 64'(y) * 64'(y))
                                     + $urandom_range(2) - 1);
            endcase
            send_vector(x, y, lim, 1'b0, '{'0, '0});
         end
         // Sender pauses until everything is back
         drain();
      end

      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("covered %0d results, %0d clamped vectors, under idle and stall phases",
               results_seen, clamps_sent);
      if (mismatches == 0 && clamped_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
